// ===== rtl/sx_pkg.sv =====
// Shared types and constants for the Soundex encoder.
`default_nettype none

package sx_pkg;

    // Number of digits that follow the code letter
    localparam int CODE_DIGITS = 3;

    // Upper bits that turn a digit 0..6 into ASCII '0'..'6'
    localparam logic [2:0] ASCII_DIGIT_HI = 3'b110;

    typedef logic [7:0] t_sx_char;
    typedef logic [2:0] t_sx_digit;
    typedef logic [1:0] t_sx_count;
    typedef logic [5:0] t_sx_ascii_digit;

    // One character step handed from the input stage to the code state
    typedef struct packed {
        logic     advance;
        logic     last;
        t_sx_char ch;
    } t_sx_step;

    // A finished four-character code
    typedef struct packed {
        t_sx_char        letter;
        t_sx_ascii_digit digit_one;
        t_sx_ascii_digit digit_two;
        t_sx_ascii_digit digit_three;
    } t_sx_code;

endpackage

`default_nettype wire

// ===== rtl/sx_ifs.sv =====
// Stream interfaces for character words in and code words out.
`default_nettype none

interface sx_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_in;
    logic       last_char;

    modport source (output valid, output char_in, output last_char, input ready);
    modport sink   (input valid, input char_in, input last_char, output ready);
endinterface

interface sx_code_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_letter;
    logic [5:0] code_digit_one;
    logic [5:0] code_digit_two;
    logic [5:0] code_digit_three;

    modport source (output valid, output code_letter, output code_digit_one,
                    output code_digit_two, output code_digit_three, input ready);
    modport sink   (input valid, input code_letter, input code_digit_one,
                    input code_digit_two, input code_digit_three, output ready);
endinterface

`default_nettype wire

// ===== rtl/sx_digit_map.sv =====
// Case fold and Soundex letter-to-digit lookup for one character.
`default_nettype none

module sx_digit_map (
    input  sx_pkg::t_sx_char  i_char,
    output sx_pkg::t_sx_char  o_upper,
    output sx_pkg::t_sx_digit o_digit
);
    import sx_pkg::*;

    localparam int          LETTERS   = 26;
    localparam t_sx_char    CHAR_A    = 8'h41;
    localparam t_sx_char    CHAR_Z    = 8'h5A;
    localparam t_sx_char    CHAR_LA   = 8'h61;
    localparam t_sx_char    CHAR_LZ   = 8'h7A;
    localparam t_sx_char    CASE_BIAS = 8'h20;

    localparam t_sx_digit LETTER_DIGIT [LETTERS] = '{
        3'd0, 3'd1, 3'd2, 3'd3, 3'd0, 3'd1, 3'd2, 3'd0, 3'd0, 3'd2, 3'd2, 3'd4, 3'd5,
        3'd5, 3'd0, 3'd1, 3'd2, 3'd6, 3'd2, 3'd3, 3'd0, 3'd1, 3'd0, 3'd2, 3'd0, 3'd2
    };

    t_sx_char   upper;
    t_sx_char   offset;

    // Fold lower case onto upper case
    always_comb begin
        if (i_char >= CHAR_LA && i_char <= CHAR_LZ) begin
            upper = i_char - CASE_BIAS;
        end else begin
            upper = i_char;
        end
    end

    assign offset  = upper - CHAR_A;
    assign o_upper = upper;

    // Look up the digit; anything that is not a letter maps to zero
    always_comb begin
        if (upper >= CHAR_A && upper <= CHAR_Z) begin
            o_digit = LETTER_DIGIT[offset[4:0]];
        end else begin
            o_digit = '0;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/sx_code_state.sv =====
// Per-name code state: letter, prior digit and collected digits.
`default_nettype none

module sx_code_state (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  sx_pkg::t_sx_step i_step,
    output sx_pkg::t_sx_code o_code
);
    import sx_pkg::*;

    t_sx_char  upper;
    t_sx_digit digit;

    logic      r_first_pending, n_first_pending;
    t_sx_char  r_held_letter,   n_held_letter;
    t_sx_digit r_prior_digit,   n_prior_digit;
    t_sx_count r_digit_count,   n_digit_count;
    t_sx_digit r_held_digits [CODE_DIGITS];
    t_sx_digit n_held_digits [CODE_DIGITS];

    sx_digit_map u_map (
        .i_char  (i_step.ch),
        .o_upper (upper),
        .o_digit (digit)
    );

    // Apply one character to the code state
    always_comb begin
        n_first_pending = r_first_pending;
        n_held_letter   = r_held_letter;
        n_prior_digit   = r_prior_digit;
        n_digit_count   = r_digit_count;
        n_held_digits   = r_held_digits;
        if (i_step.advance) begin
            if (r_first_pending) begin
                n_first_pending = 1'b0;
                n_held_letter   = upper;
                n_prior_digit   = digit;
                n_digit_count   = '0;
                for (int i = 0; i < CODE_DIGITS; i++) begin
                    n_held_digits[i] = '0;
                end
            end else if (r_digit_count != t_sx_count'(CODE_DIGITS)) begin
                if (digit != '0 && digit != r_prior_digit) begin
                    for (int i = 0; i < CODE_DIGITS; i++) begin
                        if (r_digit_count == t_sx_count'(i)) begin
                            n_held_digits[i] = digit;
                        end
                    end
                    n_digit_count = r_digit_count + 2'd1;
                end
                n_prior_digit = digit;
            end
        end
    end

    // Form the code from the updated state
    assign o_code.letter      = n_held_letter;
    assign o_code.digit_one   = {ASCII_DIGIT_HI, n_held_digits[0]};
    assign o_code.digit_two   = {ASCII_DIGIT_HI, n_held_digits[1]};
    assign o_code.digit_three = {ASCII_DIGIT_HI, n_held_digits[2]};

    // Hold state; return to the empty state after the final character
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_step.advance && i_step.last)) begin
            r_first_pending <= 1'b1;
            r_held_letter   <= '0;
            r_prior_digit   <= '0;
            r_digit_count   <= '0;
            for (int i = 0; i < CODE_DIGITS; i++) begin
                r_held_digits[i] <= '0;
            end
        end else begin
            r_first_pending <= n_first_pending;
            r_held_letter   <= n_held_letter;
            r_prior_digit   <= n_prior_digit;
            r_digit_count   <= n_digit_count;
            r_held_digits   <= n_held_digits;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/soundex_encoder.sv =====
// Soundex encoder: one character word in per cycle, one code word per name.
// A final character waits in the input register while the output holds a
// code word not yet taken. The input register feeds the code state update
// and the output register in one pass.
// The output register frees the input side while a code word waits.
// Reset (i_rst_n low, synchronous) empties both registers and the name state.
`default_nettype none

module soundex_encoder (
    input  logic           i_clk,
    input  logic           i_rst_n,
    sx_char_if.sink        i_char,
    sx_code_if.source      o_code
);
    import sx_pkg::*;

    logic     r_in_valid;
    logic     r_in_last;
    t_sx_char r_in_char;
    logic     r_out_valid;
    t_sx_code r_out_code;

    logic     out_free;
    logic     advance;
    t_sx_step step;
    t_sx_code code;

    // Advance a character unless it ends a name and the output is full
    assign out_free = !r_out_valid || o_code.ready;
    assign advance  = r_in_valid && (!r_in_last || out_free);
    assign i_char.ready = !r_in_valid || advance;

    assign step.advance = advance;
    assign step.last    = r_in_last;
    assign step.ch      = r_in_char;

    sx_code_state u_state (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .o_code  (code)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_char.ready) begin
            r_in_valid <= i_char.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_char.ready && i_char.valid) begin
            r_in_char <= i_char.char_in;
            r_in_last <= i_char.last_char;
        end
    end

    // Output register: load on the final character, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && r_in_last) begin
            r_out_valid <= 1'b1;
        end else if (o_code.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && r_in_last) begin
            r_out_code <= code;
        end
    end

    assign o_code.valid            = r_out_valid;
    assign o_code.code_letter      = r_out_code.letter;
    assign o_code.code_digit_one   = r_out_code.digit_one;
    assign o_code.code_digit_two   = r_out_code.digit_two;
    assign o_code.code_digit_three = r_out_code.digit_three;

endmodule

`default_nettype wire

// ===== rtl/sx_checker.sv =====
// Port-level checks for the Soundex encoder, bound to the top level.
`default_nettype none

module sx_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_letter,
    input logic [5:0] i_digit_one,
    input logic [5:0] i_digit_two,
    input logic [5:0] i_digit_three
);
    localparam logic [5:0] ASCII_0 = 6'h30;
    localparam logic [5:0] ASCII_6 = 6'h36;

    // No code word right after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("code word shown after reset");

    // Stalled code word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_letter)
            && $stable(i_digit_one) && $stable(i_digit_two) && $stable(i_digit_three))
        else $error("stalled code word changed");

    // Digits are ASCII zero to six
    a_digit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_digit_one >= ASCII_0 && i_digit_one <= ASCII_6
            && i_digit_two >= ASCII_0 && i_digit_two <= ASCII_6
            && i_digit_three >= ASCII_0 && i_digit_three <= ASCII_6)
        else $error("code digit out of range");

    // Digits fill in order: no filled position after an empty one
    a_digit_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_digit_one != ASCII_0 || i_digit_two == ASCII_0)
            && (i_digit_two != ASCII_0 || i_digit_three == ASCII_0))
        else $error("code digits out of order");

endmodule

bind soundex_encoder sx_checker u_sx_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_out_valid   (o_code.valid),
    .i_out_ready   (o_code.ready),
    .i_letter      (o_code.code_letter),
    .i_digit_one   (o_code.code_digit_one),
    .i_digit_two   (o_code.code_digit_two),
    .i_digit_three (o_code.code_digit_three)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for the Soundex encoder: character words in, code words out.

module testbench;
    import sx_pkg::*;

    localparam int CLK_HALF    = 4;
    localparam int RESET_LEN   = 7;
    localparam int HOLD_CYCLES = 160;
    localparam int DRAIN_WAIT  = 6;
    localparam int CYCLE_LIMIT = 200000;
    localparam int SHOW_LIMIT  = 10;

    logic i_clk = 1'b0;
    logic i_rst_n;

    sx_char_if char_if ();
    sx_code_if code_if ();

    soundex_encoder u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_char  (char_if),
        .o_code  (code_if)
    );

    // Free-running clock
    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    // Idle and stall odds, percent per cycle
    int snd_idle_pct;
    int rcv_stall_pct;

    // Long receiver hold-off, requested by the test sequence
    int hold_req;
    int hold_ack = 0;
    int hold_left = 0;

    // Encoder state as predicted from the accepted character words
    logic      name_start;
    t_sx_char  name_letter;
    t_sx_digit prev_digit;
    t_sx_count digit_cnt;
    t_sx_digit name_digits [CODE_DIGITS];

    t_sx_code pending_codes [$];
    int       bad_count;
    int       cycle_cnt = 0;

    function automatic t_sx_char fold_case(t_sx_char c);
        if (c >= "a" && c <= "z") begin
            return c - 8'h20;
        end
        return c;
    endfunction

    // Map a character to its Soundex digit; anything but a letter gives zero
    function automatic t_sx_digit soundex_digit(t_sx_char c);
        case (fold_case(c))
            "B", "F", "P", "V": return 3'd1;
            "C", "G", "J", "K", "Q", "S", "X", "Z": return 3'd2;
            "D", "T": return 3'd3;
            "L": return 3'd4;
            "M", "N": return 3'd5;
            "R": return 3'd6;
            default: return 3'd0;
        endcase
    endfunction

    function automatic void clear_name();
        name_start  = 1'b1;
        name_letter = '0;
        prev_digit  = '0;
        digit_cnt   = '0;
        for (int i = 0; i < CODE_DIGITS; i++) begin
            name_digits[i] = '0;
        end
    endfunction

    // Advance the predicted name state by one word; queue a code on the last one
    function automatic void encode_char(t_sx_char ch, logic last);
        t_sx_digit d;
        t_sx_code  code;
        if (name_start) begin
            name_letter = fold_case(ch);
            prev_digit  = soundex_digit(ch);
            digit_cnt   = '0;
            for (int i = 0; i < CODE_DIGITS; i++) begin
                name_digits[i] = '0;
            end
            name_start = 1'b0;
        end else if (digit_cnt < CODE_DIGITS) begin
            d = soundex_digit(ch);
            if (d != 0 && d != prev_digit) begin
                name_digits[digit_cnt] = d;
                digit_cnt = digit_cnt + 1'b1;
            end
            prev_digit = d;
        end
        if (last) begin
            code.letter      = name_letter;
            code.digit_one   = {ASCII_DIGIT_HI, name_digits[0]};
            code.digit_two   = {ASCII_DIGIT_HI, name_digits[1]};
            code.digit_three = {ASCII_DIGIT_HI, name_digits[2]};
            pending_codes.push_back(code);
            clear_name();
        end
    endfunction

    // Offer one character word after a random gap and hold it until taken
    task automatic send_char(input t_sx_char ch, input logic last);
        while ($urandom_range(99) < snd_idle_pct) begin
            char_if.valid   <= 1'b0;
            char_if.char_in <= 8'($urandom);
            @(posedge i_clk);
        end
        char_if.valid     <= 1'b1;
        char_if.char_in   <= ch;
        char_if.last_char <= last;
        do @(posedge i_clk); while (!char_if.ready);
        encode_char(ch, last);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(s[i], i == s.len() - 1);
        end
    endtask

    // Mostly letters of either case, now and then any byte at all
    function automatic t_sx_char random_char();
        int r;
        r = $urandom_range(99);
        if (r < 40) begin
            return 8'(8'h41 + $urandom_range(25));
        end else if (r < 80) begin
            return 8'(8'h61 + $urandom_range(25));
        end
        return 8'($urandom_range(255));
    endfunction

    task automatic send_random_names(input int n_words, input int max_len);
        int sent;
        int len;
        sent = 0;
        while (sent < n_words) begin
            if ($urandom_range(9) == 0) begin
                len = $urandom_range(24, 9);
            end else begin
                len = $urandom_range(max_len, 1);
            end
            for (int i = 0; i < len; i++) begin
                send_char(random_char(), i == len - 1);
            end
            sent += len;
        end
    endtask

    // Drop valid and wait until every predicted code word has come back
    task automatic wait_drained();
        char_if.valid <= 1'b0;
        do @(posedge i_clk); while (pending_codes.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic test_directed();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        // one-character names: lower case, NUL and all ones as the letter
        send_text("a");
        send_char(8'h00, 1'b1);
        send_char(8'hFF, 1'b1);
        // vowels and H split equal digits
        send_text("Ashcraft");
        // a non-letter clears the previous digit
        send_text("b1b");
        // code full after three digits, rest ignored
        send_text("bcdlmr");
        // NUL inside a name is an ordinary non-letter
        send_char("b", 1'b0);
        send_char(8'h00, 1'b0);
        send_char("b", 1'b1);
        wait_drained();
    endtask

    task automatic test_random(input int idle_pct, input int stall_pct, input int n_words);
        snd_idle_pct  = idle_pct;
        rcv_stall_pct = stall_pct;
        send_random_names(n_words, 8);
        wait_drained();
    endtask

    // Hold the receiver off while short names stream in, so the input stalls
    task automatic test_backpressure();
        snd_idle_pct  = 0;
        rcv_stall_pct = 0;
        hold_req <= hold_req + 1;
        send_random_names(80, 2);
        wait_drained();
    endtask

    // Hold-off countdown
    always @(posedge i_clk) begin
        if (hold_ack != hold_req) begin
            hold_left <= HOLD_CYCLES;
            hold_ack  <= hold_req;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Drive ready and check each accepted code word against the oldest prediction
    always @(posedge i_clk) begin
        t_sx_code got;
        t_sx_code want;
        code_if.ready <= (hold_left == 0) && ($urandom_range(99) >= rcv_stall_pct);
        if (i_rst_n && code_if.valid && code_if.ready) begin
            got.letter      = code_if.code_letter;
            got.digit_one   = code_if.code_digit_one;
            got.digit_two   = code_if.code_digit_two;
            got.digit_three = code_if.code_digit_three;
            if (pending_codes.size() == 0) begin
                bad_count++;
                if (bad_count <= SHOW_LIMIT) begin
                    $display("unexpected code word %h %h %h %h", got.letter,
                             got.digit_one, got.digit_two, got.digit_three);
                end
            end else begin
                want = pending_codes.pop_front();
                if (got.letter != want.letter || got.digit_one != want.digit_one ||
                        got.digit_two != want.digit_two ||
                        got.digit_three != want.digit_three) begin
                    bad_count++;
                    if (bad_count <= SHOW_LIMIT) begin
                        $display("code mismatch: expected %h %h %h %h, got %h %h %h %h",
                                 want.letter, want.digit_one, want.digit_two,
                                 want.digit_three, got.letter, got.digit_one,
                                 got.digit_two, got.digit_three);
                    end
                end
            end
        end
    end

    // Stop a hung run
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        i_rst_n           <= 1'b0;
        char_if.valid     <= 1'b0;
        char_if.char_in   <= '0;
        char_if.last_char <= 1'b0;
        hold_req          <= 0;
        snd_idle_pct      = 0;
        rcv_stall_pct     = 0;
        bad_count         = 0;
        clear_name();
        repeat (RESET_LEN) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(0, 0, 300);
        test_random(65, 0, 300);
        test_random(0, 65, 300);
        test_random(32, 32, 300);
        test_backpressure();
        test_random(0, 0, 60);

        if (bad_count == 0 && pending_codes.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
